// ===== design/cdt_pkg.sv =====
// Package for the conditional directive tracker: codes, types, defaults and name helper.
package cdt_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int NAME_CHARS_DEF  = 8;
  localparam int NEST_MAX_DEF    = 255;
  localparam int NAME_W          = 64;

  typedef enum logic [2:0] {
    CMD_DEFINE = 3'd0,
    CMD_IFDEF  = 3'd1,
    CMD_IFNDEF = 3'd2,
    CMD_ELSE   = 3'd3,
    CMD_ENDIF  = 3'd4,
    CMD_OTHER  = 3'd5,
    CMD_IF     = 3'd6,
    CMD_LINE   = 3'd7
  } cdt_cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_UNMATCHED = 3'd2,
    ST_IF        = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_HALTED    = 3'd5
  } cdt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC
  } cdt_state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } cdt_mem_ctl_t;

  typedef struct packed {
    logic rd_vld;
    logic match;
  } cdt_mem_sts_t;

  // Keeps the bytes before the first NUL, at most nchars of them; the rest reads as zero.
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw,
                                                   input int nchars);
    logic [NAME_W-1:0] res;
    logic              stop;
    res  = '0;
    stop = 1'b0;
    for (int k = 0; k < NAME_W / 8; k++) begin
      if (k >= nchars || raw[8*k +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[8*k +: 8] = raw[8*k +: 8];
      end
    end
    return res;
  endfunction

endpackage

// ===== design/cdt_name_store.sv =====
// Name table memory with a registered read port and the shared name comparator.
module cdt_name_store #(
  parameter int TABLE_DEPTH = cdt_pkg::TABLE_DEPTH_DEF,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cdt_pkg::cdt_mem_ctl_t     ctl_i,
  input  logic [IW-1:0]             waddr_i,
  input  logic [cdt_pkg::NAME_W-1:0] wdata_i,
  input  logic [IW-1:0]             raddr_i,
  input  logic [cdt_pkg::NAME_W-1:0] key_i,
  output cdt_pkg::cdt_mem_sts_t     sts_o
);

  logic [cdt_pkg::NAME_W-1:0] mem_r [TABLE_DEPTH];
  logic [cdt_pkg::NAME_W-1:0] rdata_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl_i.wr_en) begin
      mem_r[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_r <= mem_r[raddr_i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= ctl_i.rd_en;
    end
  end

  assign sts_o.rd_vld = rd_vld_r;
  assign sts_o.match  = rd_vld_r && (rdata_r == key_i);

endmodule

// ===== design/conditional_directive_tracker_core.sv =====
// Top level of the conditional directive tracker: sequencer, nesting counters and result port.
//
// Usage. The block takes one pre-parsed source line per transfer: a command code on
// in_command and a NUL-padded name on in_symbol_name. A transfer happens at a rising
// edge where start is high and busy is low. Every accepted line gives exactly one
// result, shown for a single cycle with out_valid high, carrying out_pass_line,
// out_now_suppressing and out_status. The receiver cannot hold results off, so none is
// ever stalled; the block simply drops busy again once the result is registered.
//
// Timing. Most lines go through the execute state and then the result registers. An
// ifdef or ifndef that is not inside a false conditional, with names stored and the
// halt flag clear, walks the stored names one per cycle through the single read port
// of the name table and one shared 64-bit comparator, and stops early on the first match.
// A new line can be accepted in the cycle in which the previous result is shown.
//
// Reset. rst_n is synchronous and active low; it clears the name count, both nesting
// depths, the suppress flag and the halt flag. The name table itself is not cleared:
// only entries below the name count are ever read. Once a fatal error has set the
// halt flag, every later line answers with the halted status until the next reset.
module conditional_directive_tracker_core #(
  parameter int TABLE_DEPTH = cdt_pkg::TABLE_DEPTH_DEF,
  parameter int NAME_CHARS  = cdt_pkg::NAME_CHARS_DEF,
  parameter int NEST_MAX    = cdt_pkg::NEST_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_command,
  input  logic [cdt_pkg::NAME_W-1:0] in_symbol_name,
  output logic                       out_valid,
  output logic                       out_pass_line,
  output logic                       out_now_suppressing,
  output logic [2:0]                 out_status
);

  // Widths follow from the parameters: the name count must reach TABLE_DEPTH itself,
  // the table index only TABLE_DEPTH-1, and a depth only NEST_MAX.
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = $clog2(NEST_MAX + 1);

  cdt_pkg::cdt_state_t  state_r, state_nxt;
  cdt_pkg::cdt_cmd_t    cmd_r, cmd_nxt;
  logic [cdt_pkg::NAME_W-1:0] key_r, key_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 found_r, found_nxt;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [DW-1:0]        tdep_r, tdep_nxt;
  logic [DW-1:0]        fdep_r, fdep_nxt;
  logic                 sup_r, sup_nxt;
  logic                 halt_r, halt_nxt;

  logic                 oval_r, oval_nxt;
  logic                 opass_r, opass_nxt;
  logic                 osup_r, osup_nxt;
  cdt_pkg::cdt_status_t ost_r, ost_nxt;

  cdt_pkg::cdt_mem_ctl_t mem_ctl;
  cdt_pkg::cdt_mem_sts_t mem_sts;

  logic accept;
  logic need_look;
  logic more_to_read;
  logic do_exec;

  assign busy         = (state_r != cdt_pkg::S_IDLE);
  assign accept       = start && !busy;
  // A name lookup is needed only for ifdef or ifndef in live text with names stored.
  assign need_look    = !halt_r && !sup_r && (cnt_r != '0) &&
                        ((cdt_pkg::cdt_cmd_t'(in_command) == cdt_pkg::CMD_IFDEF) ||
                         (cdt_pkg::cdt_cmd_t'(in_command) == cdt_pkg::CMD_IFNDEF));
  assign more_to_read = (idx_r < cnt_r);

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdt_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = need_look ? cdt_pkg::S_LOOK : cdt_pkg::S_EXEC;
        end
      end
      cdt_pkg::S_LOOK: begin
        // Finish on a hit, or once every issued read has been compared.
        if (mem_sts.match || (!more_to_read && !mem_sts.rd_vld)) begin
          state_nxt = cdt_pkg::S_EXEC;
        end
      end
      cdt_pkg::S_EXEC: begin
        state_nxt = cdt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = cdt_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: table read during the walk, table write and update on execute.
  always_comb begin
    mem_ctl = '0;
    do_exec = 1'b0;
    case (state_r)
      cdt_pkg::S_IDLE: begin
        mem_ctl = '0;
      end
      cdt_pkg::S_LOOK: begin
        mem_ctl.rd_en = more_to_read && !mem_sts.match;
      end
      cdt_pkg::S_EXEC: begin
        do_exec       = 1'b1;
        mem_ctl.wr_en = !halt_r && !sup_r && (cmd_r == cdt_pkg::CMD_DEFINE) &&
                        (cnt_r != CW'(TABLE_DEPTH));
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  // Capture of the line and progress of the walk.
  always_comb begin
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    if (accept) begin
      cmd_nxt   = cdt_pkg::cdt_cmd_t'(in_command);
      key_nxt   = cdt_pkg::canon_name(in_symbol_name, NAME_CHARS);
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end else if (state_r == cdt_pkg::S_LOOK) begin
      if (mem_ctl.rd_en) begin
        idx_nxt = idx_r + CW'(1);
      end
      if (mem_sts.match) begin
        found_nxt = 1'b1;
      end
    end
  end

  // Directive semantics, applied once per line in the execute cycle.
  always_comb begin
    cnt_nxt   = cnt_r;
    tdep_nxt  = tdep_r;
    fdep_nxt  = fdep_r;
    sup_nxt   = sup_r;
    halt_nxt  = halt_r;
    oval_nxt  = 1'b0;
    opass_nxt = 1'b0;
    osup_nxt  = osup_r;
    ost_nxt   = cdt_pkg::ST_OK;
    if (do_exec) begin
      oval_nxt = 1'b1;
      if (halt_r) begin
        ost_nxt = cdt_pkg::ST_HALTED;
      end else begin
        case (cmd_r)
          cdt_pkg::CMD_DEFINE: begin
            if (!sup_r) begin
              if (cnt_r == CW'(TABLE_DEPTH)) begin
                ost_nxt  = cdt_pkg::ST_FULL;
                halt_nxt = 1'b1;
              end else begin
                cnt_nxt   = cnt_r + CW'(1);
                opass_nxt = 1'b1;
              end
            end
          end
          cdt_pkg::CMD_IFDEF, cdt_pkg::CMD_IFNDEF: begin
            if (sup_r || (found_r != (cmd_r == cdt_pkg::CMD_IFDEF))) begin
              // Opens a false conditional, or nests one inside dead text.
              if (fdep_r == DW'(NEST_MAX)) begin
                ost_nxt = cdt_pkg::ST_OVERFLOW;
              end else begin
                fdep_nxt = fdep_r + DW'(1);
              end
              sup_nxt = 1'b1;
            end else begin
              if (tdep_r == DW'(NEST_MAX)) begin
                ost_nxt = cdt_pkg::ST_OVERFLOW;
              end else begin
                tdep_nxt = tdep_r + DW'(1);
              end
            end
          end
          cdt_pkg::CMD_ELSE: begin
            if (tdep_r == '0 && fdep_r == '0) begin
              ost_nxt  = cdt_pkg::ST_UNMATCHED;
              halt_nxt = 1'b1;
            end else if (fdep_r != '0) begin
              // Only the outermost false conditional turns true; inner ones stay dead.
              if (fdep_r == DW'(1)) begin
                if (tdep_r == DW'(NEST_MAX)) begin
                  ost_nxt = cdt_pkg::ST_OVERFLOW;
                end else begin
                  tdep_nxt = tdep_r + DW'(1);
                end
                fdep_nxt = '0;
                sup_nxt  = 1'b0;
              end
            end else begin
              tdep_nxt = tdep_r - DW'(1);
              fdep_nxt = DW'(1);
              sup_nxt  = 1'b1;
            end
          end
          cdt_pkg::CMD_ENDIF: begin
            if (tdep_r == '0 && fdep_r == '0) begin
              ost_nxt  = cdt_pkg::ST_UNMATCHED;
              halt_nxt = 1'b1;
            end else if (fdep_r != '0) begin
              fdep_nxt = fdep_r - DW'(1);
              if (fdep_r == DW'(1)) begin
                sup_nxt = 1'b0;
              end
            end else begin
              tdep_nxt = tdep_r - DW'(1);
            end
          end
          cdt_pkg::CMD_OTHER: begin
            opass_nxt = !sup_r;
          end
          cdt_pkg::CMD_IF: begin
            ost_nxt  = cdt_pkg::ST_IF;
            halt_nxt = 1'b1;
          end
          cdt_pkg::CMD_LINE: begin
            ost_nxt = cdt_pkg::ST_OK;
          end
          default: begin
            ost_nxt = cdt_pkg::ST_OK;
          end
        endcase
      end
      osup_nxt = sup_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdt_pkg::S_IDLE;
      cnt_r   <= '0;
      tdep_r  <= '0;
      fdep_r  <= '0;
      sup_r   <= 1'b0;
      halt_r  <= 1'b0;
      oval_r  <= 1'b0;
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tdep_r  <= tdep_nxt;
      fdep_r  <= fdep_nxt;
      sup_r   <= sup_nxt;
      halt_r  <= halt_nxt;
      oval_r  <= oval_nxt;
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    key_r   <= key_nxt;
    opass_r <= opass_nxt;
    osup_r  <= osup_nxt;
    ost_r   <= ost_nxt;
  end

  cdt_name_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (mem_ctl),
    .waddr_i (cnt_r[IW-1:0]),
    .wdata_i (key_r),
    .raddr_i (idx_r[IW-1:0]),
    .key_i   (key_r),
    .sts_o   (mem_sts)
  );

  assign out_valid           = oval_r;
  assign out_pass_line       = opass_r;
  assign out_now_suppressing = osup_r;
  assign out_status          = ost_r;

endmodule
